// File: design/ffhs_pkg.sv
// Package for the feature frame history stacker.
// Holds the sizing constants, codes, queue entry type and register helper.
// No dependencies; every other file of the block imports it.
package ffhs_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int MAX_LENGTH  = 8;
  localparam int WORD_W      = 32;
  localparam int REG_W       = 4;
  localparam int POS_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int IDX_W       = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_W       = $clog2(MAX_LENGTH + 2);
  localparam int CMP_W       = REG_W + POS_W + CNT_W;
  localparam int ROW_W       = MAX_LENGTH * WORD_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [REG_W-1:0] NF_RESET = REG_W'((MAX_FRAMES < 8) ? MAX_FRAMES : 8);
  localparam logic [REG_W-1:0] FL_RESET = REG_W'((MAX_LENGTH < 8) ? MAX_LENGTH : 8);

  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEW_MODE      = 2'd2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } back_state_t;

  // One classified input item, as passed from the front to the back.
  typedef struct packed {
    logic              is_clear;
    logic              stage_en;
    logic [IDX_W-1:0]  stage_idx;
    logic [WORD_W-1:0] value;
    logic              commit;
    logic              emit;
    logic              err;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  start;
  } queue_entry_t;

  // Register value clipped to its maximum.
  function automatic logic [REG_W-1:0] sat_reg(input logic [REG_W-1:0] v, input int maxv);
    logic [REG_W-1:0] lim;
    lim = REG_W'(maxv);
    sat_reg = (v > lim) ? lim : v;
  endfunction

endpackage

// File: design/ffhs_front.sv
// Front part of the history stacker: accepts items and classifies them.
// Tracks the element count and ring position; depends on ffhs_pkg.
module ffhs_front import ffhs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [REG_W-1:0]   ring_slots,
  input  logic [REG_W-1:0]   feature_length,
  input  logic               spew_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [WORD_W-1:0]  element_value,
  input  logic               frame_end,
  input  logic               q_full,
  output logic               q_push,
  output queue_entry_t       q_data
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] count_inc;
  logic [POS_W-1:0] wp;
  logic [POS_W-1:0] wp_next;
  logic [POS_W:0]   wp_post;
  logic             ring_full;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    count_inc = (count < CNT_W'(MAX_LENGTH + 1)) ? count + CNT_W'(1) : count;
    wp_post   = {1'b0, wp} + (POS_W + 1)'(1);
    ring_full = (CMP_W'(wp_post) == CMP_W'(ring_slots));

    q_data           = '0;
    q_data.value     = element_value;
    q_data.stage_idx = count[IDX_W-1:0];
    q_data.row       = wp;
    count_next       = count;
    wp_next          = wp;

    if (op == OP_CLEAR) begin
      q_data.is_clear = 1'b1;
      count_next      = '0;
      wp_next         = '0;
    end else begin
      q_data.stage_en = (count < CNT_W'(MAX_LENGTH));
      if (frame_end) begin
        q_data.err    = (CMP_W'(count_inc) != CMP_W'(feature_length));
        q_data.commit = !q_data.err;
        q_data.emit   = ring_full || spew_mode;
        q_data.start  = ring_full ? '0 : wp_post[POS_W-1:0];
        wp_next       = ring_full ? '0 : wp_post[POS_W-1:0];
        count_next    = '0;
      end else begin
        count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
      wp    <= '0;
    end else if (accept) begin
      count <= count_next;
      wp    <= wp_next;
    end
  end

endmodule

// File: design/ffhs_queue.sv
// Short queue of classified items between the front and the back.
// Register array with read and write pointers; depends on ffhs_pkg.
module ffhs_queue import ffhs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_data,
  input  logic         pop,
  output queue_entry_t head,
  output logic         full,
  output logic         empty
);

  queue_entry_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: design/ffhs_back.sv
// Back part of the history stacker: staging, frame store and history runs.
// The store is a row-wide memory with one valid bit per row; depends on ffhs_pkg.
module ffhs_back import ffhs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  logic [REG_W-1:0]   ring_slots,
  input  logic [REG_W-1:0]   feature_length,
  input  logic               q_empty,
  input  queue_entry_t       q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [WORD_W-1:0]  out_value,
  output logic               run_last,
  output logic               length_error
);

  back_state_t       state;
  back_state_t       state_next;
  logic [WORD_W-1:0] staging [MAX_LENGTH];
  logic [ROW_W-1:0]  store [MAX_FRAMES];
  logic [ROW_W-1:0]  row_wdata;
  logic [ROW_W-1:0]  rd_row;
  logic              rd_ok;
  logic [MAX_FRAMES-1:0] row_valid;
  logic [POS_W-1:0]  slot;
  logic [POS_W-1:0]  slot_next;
  logic [POS_W-1:0]  k;
  logic [IDX_W-1:0]  j;
  logic              err_run;
  logic              send;
  logic              last_j;
  logic              last_k;
  logic              do_elem;

  assign q_pop   = (state == BK_IDLE) && !q_empty;
  assign do_elem = q_pop && !q_data.is_clear;
  assign send    = (state == BK_SEND) && (!out_valid || !out_stall);
  assign last_j  = ((REG_W'(j) + REG_W'(1)) == feature_length);
  assign last_k  = ((REG_W'(k) + REG_W'(1)) == ring_slots);
  assign slot_next = ((REG_W'(slot) + REG_W'(1)) == ring_slots) ? '0 : slot + POS_W'(1);

  // The row written at commit includes the final element of the frame.
  always_comb begin
    for (int i = 0; i < MAX_LENGTH; i++) begin
      row_wdata[i*WORD_W +: WORD_W] =
          (q_data.stage_en && (q_data.stage_idx == IDX_W'(i))) ? q_data.value : staging[i];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (do_elem && q_data.emit) begin
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_SEND;
      BK_SEND: begin
        if (send && last_j) begin
          state_next = last_k ? BK_IDLE : BK_READ;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_elem && q_data.stage_en) begin
      staging[q_data.stage_idx] <= q_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (do_elem && q_data.commit) begin
      store[q_data.row] <= row_wdata;
    end
    if (state == BK_READ) begin
      rd_row <= store[slot];
      rd_ok  <= row_valid[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear || (q_pop && q_data.is_clear)) begin
      row_valid <= '0;
    end else if (do_elem && q_data.commit) begin
      row_valid[q_data.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_elem && q_data.emit) begin
      slot    <= q_data.start;
      k       <= '0;
      j       <= '0;
      err_run <= q_data.err;
    end else if (send) begin
      if (last_j) begin
        j    <= '0;
        k    <= k + POS_W'(1);
        slot <= slot_next;
      end else begin
        j <= j + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (send) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_value    <= rd_ok ? rd_row[j*WORD_W +: WORD_W] : '0;
      run_last     <= last_j && last_k;
      length_error <= err_run;
    end
  end

endmodule

// File: design/feature_frame_history_stacker.sv
// Top level of the feature frame history stacker.
// Holds the configuration registers and joins front, queue and back; depends on ffhs_pkg.
//
//   Port group   Direction  Handshake           Payload
//   input item   in         in_valid/in_stall   op, element_value, frame_end
//   result item  out        out_valid/out_stall out_value, run_last, length_error
//   config       in         cfg_write           cfg_index, cfg_data
//
// The front takes one item per cycle while the four-entry queue has room.
// The back drains one queued item per cycle; an item that triggers a run then holds
// the back while it reads each row of the frame store in turn and emits its words, and
// output stalls lengthen the run.
// Reset is synchronous and needs no clearing pass: the store has one valid bit per
// row, and a row that is not valid reads as zero.
// A stalled result sits in the output register while the front keeps filling the queue.

module feature_frame_history_stacker import ffhs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [WORD_W-1:0]    element_value,
  input  logic                 frame_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    out_value,
  output logic                 run_last,
  output logic                 length_error
);

  logic [REG_W-1:0] ring_slots;
  logic [REG_W-1:0] feature_length;
  logic             spew_mode;
  logic [REG_W-1:0] nf_sat;
  logic [REG_W-1:0] fl_sat;
  logic             cfg_clear;

  queue_entry_t push_data;
  queue_entry_t head;
  logic         push;
  logic         pop;
  logic         q_full;
  logic         q_empty;

  // A write of zero to either size register is dropped. An accepted size write also
  // empties the store and restarts the ring position, as a clear item would.
  assign nf_sat = sat_reg(cfg_data, MAX_FRAMES);
  assign fl_sat = sat_reg(cfg_data, MAX_LENGTH);

  always_comb begin
    cfg_clear = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        CFG_NUM_FRAMES:     cfg_clear = (nf_sat != '0);
        CFG_FEATURE_LENGTH: cfg_clear = (fl_sat != '0);
        default:            cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_slots     <= NF_RESET;
      feature_length <= FL_RESET;
      spew_mode      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_NUM_FRAMES: begin
          if (nf_sat != '0) begin
            ring_slots <= nf_sat;
          end
        end
        CFG_FEATURE_LENGTH: begin
          if (fl_sat != '0) begin
            feature_length <= fl_sat;
          end
        end
        CFG_SPEW_MODE: spew_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front decides per item where it is staged, whether the frame commits, and
  // whether a run follows and from which slot it starts.
  ffhs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .clear          (cfg_clear),
    .ring_slots     (ring_slots),
    .feature_length (feature_length),
    .spew_mode      (spew_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .element_value  (element_value),
    .frame_end      (frame_end),
    .q_full         (q_full),
    .q_push         (push),
    .q_data         (push_data)
  );

  ffhs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back owns the staging buffer and the frame store and plays out the runs.
  ffhs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .clear          (cfg_clear),
    .ring_slots     (ring_slots),
    .feature_length (feature_length),
    .q_empty        (q_empty),
    .q_data         (head),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .run_last       (run_last),
    .length_error   (length_error)
  );

endmodule

// File: verif/feature_frame_history_stacker_tb.sv
// Self-checking testbench for the feature frame history stacker.
// Holds a history scoreboard class with its own predictor, plus tasks that drive and drain the
// block; depends on ffhs_pkg and the feature_frame_history_stacker RTL.
module feature_frame_history_stacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffhs_pkg::*;

  // Register index that the block does not decode; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int ITEM_TARGET  = 430;  // input items in the whole run
  localparam int DRAIN_CYCLES = 24;   // queue depth plus back-end turnaround, with margin
  localparam int QUIET_LIMIT  = 2000; // cycles with no handshake before the run is abandoned

  // One emitted history word as the block should present it.
  typedef struct {
    logic [WORD_W-1:0] value;
    logic              last;
    logic              err;
  } history_word_t;

  // Scoreboard: keeps a private copy of the ring, the staging buffer, the position and the
  // registers, predicts the run that each accepted item causes, and checks results in order.
  class history_scoreboard;
    logic [WORD_W-1:0] ring [MAX_FRAMES][MAX_LENGTH];
    logic [WORD_W-1:0] staged [MAX_LENGTH];
    int                slot_pos;
    int                staged_count;
    int                frames;
    int                length;
    bit                spew;
    history_word_t     pending_words[$];
    int                mismatches;
    int                words_checked;
    int                runs;
    int                bad_runs;

    function new();
      wipe_history();
      frames = int'(NF_RESET);
      length = int'(FL_RESET);
      spew = 1'b0;
      mismatches = 0;
      words_checked = 0;
      runs = 0;
      bad_runs = 0;
    endfunction

    function void wipe_history();
      foreach (ring[f, e]) ring[f][e] = '0;
      slot_pos = 0;
      staged_count = 0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // Zero or out-of-range sizes follow the block's rules: zero is dropped, large values clip.
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      int v;
      v = int'(data);
      case (idx)
        CFG_NUM_FRAMES: begin
          if (v > MAX_FRAMES) v = MAX_FRAMES;
          if (v != 0) begin
            frames = v;
            wipe_history();
          end
        end
        CFG_FEATURE_LENGTH: begin
          if (v > MAX_LENGTH) v = MAX_LENGTH;
          if (v != 0) begin
            length = v;
            wipe_history();
          end
        end
        CFG_SPEW_MODE: spew = data[0];
        default: ;
      endcase
    endfunction

    function void predict_item(logic kind, logic [WORD_W-1:0] value, logic frame_end);
      bit err;
      int slot;
      if (kind == OP_CLEAR) begin
        wipe_history();
        return;
      end
      // Elements past the staging depth are dropped, but the count still shows the overrun.
      if (staged_count < MAX_LENGTH) staged[staged_count] = value;
      if (staged_count < MAX_LENGTH + 1) staged_count++;
      if (!frame_end) return;
      err = (staged_count != length);
      staged_count = 0;
      if (!err) begin
        for (int e = 0; e < length; e++) ring[slot_pos][e] = staged[e];
      end
      slot_pos++;
      if (slot_pos != frames && !spew) return;
      // Oldest frame first: the slot after the one just written.
      for (int k = 0; k < frames; k++) begin
        slot = (k + slot_pos) % frames;
        for (int e = 0; e < length; e++) begin
          pending_words.push_back('{ring[slot][e], (k == frames - 1) && (e == length - 1),
                                    err});
        end
      end
      runs++;
      if (err) bad_runs++;
      if (slot_pos >= frames) slot_pos = 0;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_word(logic [WORD_W-1:0] value, logic last, logic err);
      history_word_t want;
      words_checked++;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %h last %b err %b", value, last, err));
        return;
      end
      want = pending_words.pop_front();
      if (value !== want.value)
        report($sformatf("word %0d value %h, expected %h", words_checked, value, want.value));
      if (last !== want.last)
        report($sformatf("word %0d run_last %b, expected %b", words_checked, last, want.last));
      if (err !== want.err)
        report($sformatf("word %0d length_error %b, expected %b", words_checked, err,
                         want.err));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [WORD_W-1:0]    element_value;
  logic                 frame_end;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    out_value;
  logic                 run_last;
  logic                 length_error;

  history_scoreboard book;
  int                sender_calm = 0;
  int                receiver_calm = 0;
  int                items_sent = 0;
  int                elements_sent = 0;
  int                settings_used = 0;
  int                quiet_cycles = 0;

  feature_frame_history_stacker dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .element_value (element_value),
    .frame_end     (frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .run_last      (run_last),
    .length_error  (length_error)
  );

  // 20 ns clock: first rising edge at 10 ns, falling edges on multiples of 20 ns.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Wait before the next item on one side, in cycles. Mostly a uniform random draw, but now
  // and then a calm stretch of back-to-back items so the block also sees full rate.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Mostly random words, with the all-zero and all-one patterns mixed in.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Presents one item and returns on the falling edge after it was taken. Called on a
  // falling edge; valid stays high on return so a following item can go back to back.
  task automatic send_item(input logic kind, input logic [WORD_W-1:0] value,
                           input logic last_of_frame);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = kind;
    element_value = value;
    frame_end = last_of_frame;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    book.predict_item(kind, value, last_of_frame);
    items_sent++;
    if (kind == OP_ELEMENT) elements_sent++;
    @(negedge clk);
  endtask

  // A run of elements; with_end marks the final one as the end of the frame.
  task automatic send_frame(input int count, input bit with_end);
    for (int i = 0; i < count; i++)
      send_item(OP_ELEMENT, pick_word(), with_end && (i == count - 1));
  endtask

  // A clear carries random, ignored value and end fields.
  task automatic send_clear();
    send_item(OP_CLEAR, pick_word(), 1'($urandom_range(0, 1)));
  endtask

  // Holds the enable high across consecutive writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_write = 1'b1;
    book.write_register(idx, data);
    @(negedge clk);
  endtask

  // Block must be idle here. Besides the real settings, this sometimes writes a zero size
  // (which the block drops), clips an oversized value to the maximum, and pokes the
  // unused register index.
  task automatic load_settings(input int nf, input int fl, input bit mode);
    logic [REG_W-1:0] data;
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_NUM_FRAMES : CFG_FEATURE_LENGTH, '0);
    data = REG_W'(nf);
    if (nf == MAX_FRAMES && $urandom_range(0, 1)) data = REG_W'($urandom_range(MAX_FRAMES, 15));
    write_reg(CFG_NUM_FRAMES, data);
    data = REG_W'(fl);
    if (fl == MAX_LENGTH && $urandom_range(0, 1)) data = REG_W'($urandom_range(MAX_LENGTH, 15));
    write_reg(CFG_FEATURE_LENGTH, data);
    // Only bit 0 of the mode register counts; the upper bits carry noise.
    write_reg(CFG_SPEW_MODE, {REG_W'($urandom_range(0, 7)) << 1} | REG_W'(mode));
    if ($urandom_range(0, 2) == 0) write_reg(CFG_UNUSED, REG_W'($urandom_range(0, 15)));
    cfg_write = 1'b0;
    settings_used++;
  endtask

  // Waits for every predicted word, then gives the block time to retire queued items that
  // emit nothing (element items mid-frame, clears) before anything else touches it.
  task automatic settle();
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result side: draws a stall per word, then takes the next word at a rising edge.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_wait(receiver_calm);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      book.check_word(out_value, run_last, length_error);
      @(negedge clk);
    end
  end

  // Watchdog: any accepted item on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int nf;
    int fl;
    int quota;
    int phase_elements;
    int pick;
    int count;
    bit mode;

    book = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = OP_ELEMENT;
    element_value = '0;
    frame_end = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part on a two-frame, two-element ring so each case shows in a short run.
    load_settings(2, 2, 1'b0);
    // Extreme words fill the first slot; the second frame fills the ring and emits it.
    send_item(OP_ELEMENT, '0, 1'b0);
    send_item(OP_ELEMENT, '1, 1'b1);
    send_item(OP_ELEMENT, 32'hA5A5_A5A5, 1'b0);
    send_item(OP_ELEMENT, 32'h5A5A_5A5A, 1'b1);
    // A short frame is ignored but still moves the position.
    send_item(OP_ELEMENT, 32'h1234_5678, 1'b1);
    // Nine elements overrun the staging buffer; the emitted run carries the error flag and
    // the old contents.
    send_frame(MAX_LENGTH + 1, 1'b1);
    // A clear in the middle of a frame throws away the staged element and the position.
    send_item(OP_ELEMENT, pick_word(), 1'b0);
    send_item(OP_CLEAR, pick_word(), 1'b1);
    send_frame(2, 1'b1);
    send_item(OP_CLEAR, pick_word(), 1'b0);
    send_frame(2, 1'b1);
    send_frame(2, 1'b1);

    // Random part: the size and mode extremes first, then random settings.
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      case (phase)
        0:       begin nf = 1;          fl = 1;          mode = 1'b0; end
        1:       begin nf = MAX_FRAMES; fl = MAX_LENGTH; mode = 1'b1; end
        2:       begin nf = 1;          fl = MAX_LENGTH; mode = 1'b1; end
        3:       begin nf = MAX_FRAMES; fl = 1;          mode = 1'b0; end
        4:       begin nf = MAX_FRAMES; fl = MAX_LENGTH; mode = 1'b0; end
        default: begin
          nf = $urandom_range(1, MAX_FRAMES);
          fl = $urandom_range(1, MAX_LENGTH);
          mode = 1'($urandom_range(0, 1));
        end
      endcase
      settle();
      load_settings(nf, fl, mode);
      // Without spew mode a run needs the whole ring filled, so those phases last longer.
      quota = mode ? 40 : ((2 * nf * fl > 40) ? 2 * nf * fl : 40);
      phase_elements = 0;
      while (phase_elements < quota && items_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_clear();
        end else if (pick < 8) begin
          // Broken frame: a few elements, then a clear.
          count = $urandom_range(1, fl);
          send_frame(count, 1'b0);
          send_clear();
          phase_elements += count;
        end else if (pick < 20) begin
          // Wrong length, short or long, up to a few past the staging depth.
          do count = $urandom_range(1, MAX_LENGTH + 3); while (count == fl);
          send_frame(count, 1'b1);
          phase_elements += count;
        end else begin
          send_frame(fl, 1'b1);
          phase_elements += fl;
        end
      end
    end

    settle();
    if (book.pending() != 0)
      book.report($sformatf("%0d words never emitted", book.pending()));

    $display("Sent %0d items (%0d elements) under %0d register settings.",
             items_sent, elements_sent, settings_used);
    $display("Checked %0d history words in %0d runs; %0d runs flagged a wrong-length frame.",
             book.words_checked, book.runs, book.bad_runs);
    if (book.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
